FILE: design/tpcl_pkg.sv
`default_nettype none

package tpcl_pkg;

    // Field widths
    localparam int NODE_W  = 10;
    localparam int DEPTH_W = 10;
    localparam int COST_W  = 26;
    localparam int PATH_W  = 27;
    localparam int EDGE_W  = 16;

    // Default sizing
    localparam int DEF_MAX_NODES  = 1024;
    localparam int DEF_LOG_LEVELS = 10;

    // Saturation limits
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
    localparam logic [COST_W-1:0]  COST_MAX  = '1;

    // Item codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Result status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    // Per-node entry: loaded mark, depth, cost from the root
    typedef struct packed {
        logic               loaded;
        logic [DEPTH_W-1:0] depth;
        logic [COST_W-1:0]  cost;
    } node_ent_t;

    // Ancestor table entry: valid clear means none
    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] node;
    } anc_ent_t;

    // Write strobes towards the two memories
    typedef struct packed {
        logic node_we;
        logic anc_we;
    } mem_wr_t;

endpackage

`default_nettype wire

FILE: design/tpcl_seq.sv
`default_nettype none

module tpcl_seq
    import tpcl_pkg::*;
#(
    parameter int MAX_NODES  = DEF_MAX_NODES,
    parameter int LOG_LEVELS = DEF_LOG_LEVELS,
    parameter int AW         = $clog2(MAX_NODES),
    parameter int LW         = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_action,
    input  wire logic [NODE_W-1:0]   s_node_a,
    input  wire logic [NODE_W-1:0]   s_node_b,
    input  wire logic                s_is_root,
    input  wire logic [EDGE_W-1:0]   s_edge_cost,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [PATH_W-1:0]        m_path_cost,
    output logic [NODE_W-1:0]        m_lca_node,
    output logic                     m_status,
    output logic [AW-1:0]            node_ra_addr,
    output logic [AW-1:0]            node_rb_addr,
    input  wire node_ent_t           node_ra_data,
    input  wire node_ent_t           node_rb_data,
    output logic [AW-1:0]            node_wr_addr,
    output node_ent_t                node_wr_data,
    output logic [AW+LW-1:0]         anc_ra_addr,
    output logic [AW+LW-1:0]         anc_rb_addr,
    input  wire anc_ent_t            anc_ra_data,
    input  wire anc_ent_t            anc_rb_data,
    output logic [AW+LW-1:0]         anc_wr_addr,
    output anc_ent_t                 anc_wr_data,
    output mem_wr_t                  wr
);

    localparam logic [LW-1:0] LVL_TOP  = LW'(LOG_LEVELS - 1);
    localparam logic [AW-1:0] CNT_LAST = AW'(MAX_NODES - 1);

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b00_0000_0001,
        S_IDLE    = 10'b00_0000_0010,
        S_LD_CHK  = 10'b00_0000_0100,
        S_LD_FILL = 10'b00_0000_1000,
        S_Q_CHK   = 10'b00_0001_0000,
        S_Q_UP    = 10'b00_0010_0000,
        S_Q_DOWN  = 10'b00_0100_0000,
        S_Q_FIN   = 10'b00_1000_0000,
        S_Q_COST  = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       cnt_reg, cnt_next;
    logic [LW-1:0]       lvl_reg, lvl_next;
    logic [NODE_W-1:0]   a_reg, a_next;
    logic [NODE_W-1:0]   b_reg, b_next;
    logic                root_reg, root_next;
    logic [EDGE_W-1:0]   edge_reg, edge_next;
    logic [NODE_W-1:0]   u_reg, u_next;
    logic [NODE_W-1:0]   v_reg, v_next;
    logic [DEPTH_W-1:0]  dv_reg, dv_next;
    logic [PATH_W-1:0]   cab_reg, cab_next;
    anc_ent_t            prev_reg, prev_next;
    logic [PATH_W-1:0]   res_cost_reg, res_cost_next;
    logic [NODE_W-1:0]   res_anc_reg, res_anc_next;
    logic                res_st_reg, res_st_next;
    logic                m_valid_reg, m_valid_next;
    logic [PATH_W-1:0]   m_cost_reg, m_cost_next;
    logic [NODE_W-1:0]   m_anc_reg, m_anc_next;
    logic                m_st_reg, m_st_next;

    // Datapath terms
    logic [DEPTH_W:0]    depth_inc;
    logic [COST_W:0]     cost_inc;
    anc_ent_t            fill_fwd, fill_val;
    logic [16:0]         lift_lim;
    logic                lift;
    logic [NODE_W-1:0]   up_node;
    logic                down_step;
    logic [PATH_W-1:0]   two_cl;
    logic                out_free;

    function automatic logic in_range(input logic [NODE_W-1:0] n);
        return 32'(n) < MAX_NODES;
    endfunction

    function automatic logic [AW+LW-1:0] anc_addr(input logic [NODE_W-1:0] n,
                                                   input logic [LW-1:0] l);
        return {AW'(n), l};
    endfunction

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_path_cost = m_cost_reg;
    assign m_lca_node  = m_anc_reg;
    assign m_status    = m_st_reg;

    // Load: extend the parent's depth and cost, saturating
    assign depth_inc = {1'b0, node_rb_data.depth} + (DEPTH_W+1)'(1);
    assign cost_inc  = {1'b0, node_rb_data.cost} + (COST_W+1)'(edge_reg);

    // Row fill: the last written entry overrides a stale read of itself
    assign fill_fwd = (prev_reg.node == a_reg) ? prev_reg : anc_ra_data;
    assign fill_val = prev_reg.valid ? fill_fwd : '0;

    // Query lift towards the shallower endpoint's depth
    assign lift_lim = 17'(dv_reg) + (17'd1 << lvl_reg);
    assign lift     = (17'(node_ra_data.depth) >= lift_lim) && anc_ra_data.valid;
    assign up_node  = lift ? anc_ra_data.node : u_reg;

    // Joint climb while ancestors differ
    assign down_step = (anc_ra_data != anc_rb_data) && anc_ra_data.valid
                       && anc_rb_data.valid;

    assign two_cl   = {node_ra_data.cost, 1'b0};
    assign out_free = !m_valid_reg || m_ready;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        lvl_next      = lvl_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        root_next     = root_reg;
        edge_next     = edge_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        dv_next       = dv_reg;
        cab_next      = cab_reg;
        prev_next     = prev_reg;
        res_cost_next = res_cost_reg;
        res_anc_next  = res_anc_reg;
        res_st_next   = res_st_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_cost_next   = m_cost_reg;
        m_anc_next    = m_anc_reg;
        m_st_next     = m_st_reg;
        node_ra_addr  = '0;
        node_rb_addr  = '0;
        node_wr_addr  = '0;
        node_wr_data  = '0;
        anc_ra_addr   = '0;
        anc_rb_addr   = '0;
        anc_wr_addr   = '0;
        anc_wr_data   = '0;
        wr            = '0;

        unique case (state_reg)
            S_CLEAR: begin
                // Sweep the node memory, dropping every loaded mark
                wr.node_we   = 1'b1;
                node_wr_addr = cnt_reg;
                if (cnt_reg == CNT_LAST) begin
                    state_next = S_IDLE;
                end else begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_IDLE: begin
                node_ra_addr = AW'(s_node_a);
                node_rb_addr = AW'(s_node_b);
                if (s_valid) begin
                    a_next     = s_node_a;
                    b_next     = s_node_b;
                    root_next  = s_is_root;
                    edge_next  = s_edge_cost;
                    state_next = (s_action == ACT_LOAD) ? S_LD_CHK : S_Q_CHK;
                end
            end
            S_LD_CHK: begin
                res_cost_next = '0;
                res_anc_next  = '0;
                if (!in_range(a_reg) ||
                    (!root_reg && !(in_range(b_reg) && node_rb_data.loaded))) begin
                    res_st_next = ST_ERR;
                    state_next  = S_DONE;
                end else begin
                    res_st_next   = ST_OK;
                    wr.node_we    = 1'b1;
                    wr.anc_we     = 1'b1;
                    node_wr_addr  = AW'(a_reg);
                    anc_wr_addr   = anc_addr(a_reg, '0);
                    node_wr_data.loaded = 1'b1;
                    if (root_reg) begin
                        node_wr_data.depth = '0;
                        node_wr_data.cost  = '0;
                        anc_wr_data        = '0;
                    end else begin
                        node_wr_data.depth = depth_inc[DEPTH_W] ? DEPTH_MAX
                                                                : depth_inc[DEPTH_W-1:0];
                        node_wr_data.cost  = cost_inc[COST_W] ? COST_MAX
                                                              : cost_inc[COST_W-1:0];
                        anc_wr_data.valid  = 1'b1;
                        anc_wr_data.node   = b_reg;
                    end
                    prev_next   = anc_wr_data;
                    anc_ra_addr = anc_addr(anc_wr_data.node, '0);
                    if (LOG_LEVELS == 1) begin
                        state_next = S_DONE;
                    end else begin
                        lvl_next   = LW'(1);
                        state_next = S_LD_FILL;
                    end
                end
            end
            S_LD_FILL: begin
                // Write one level of the row and fetch the next lift target
                wr.anc_we   = 1'b1;
                anc_wr_addr = anc_addr(a_reg, lvl_reg);
                anc_wr_data = fill_val;
                prev_next   = fill_val;
                anc_ra_addr = anc_addr(fill_val.node, lvl_reg);
                if (lvl_reg == LVL_TOP) begin
                    state_next = S_DONE;
                end else begin
                    lvl_next = lvl_reg + LW'(1);
                end
            end
            S_Q_CHK: begin
                res_cost_next = '0;
                res_anc_next  = '0;
                if (!(in_range(a_reg) && node_ra_data.loaded &&
                      in_range(b_reg) && node_rb_data.loaded)) begin
                    res_st_next = ST_ERR;
                    state_next  = S_DONE;
                end else begin
                    // Put the deeper endpoint in u
                    if (node_ra_data.depth < node_rb_data.depth) begin
                        u_next  = b_reg;
                        v_next  = a_reg;
                        dv_next = node_ra_data.depth;
                    end else begin
                        u_next  = a_reg;
                        v_next  = b_reg;
                        dv_next = node_rb_data.depth;
                    end
                    cab_next     = PATH_W'(node_ra_data.cost) + PATH_W'(node_rb_data.cost);
                    lvl_next     = LVL_TOP;
                    node_ra_addr = AW'(u_next);
                    anc_ra_addr  = anc_addr(u_next, LVL_TOP);
                    state_next   = S_Q_UP;
                end
            end
            S_Q_UP: begin
                u_next = up_node;
                if (lvl_reg == '0) begin
                    if (up_node == v_reg) begin
                        node_ra_addr = AW'(up_node);
                        state_next   = S_Q_COST;
                    end else begin
                        lvl_next    = LVL_TOP;
                        anc_ra_addr = anc_addr(up_node, LVL_TOP);
                        anc_rb_addr = anc_addr(v_reg, LVL_TOP);
                        state_next  = S_Q_DOWN;
                    end
                end else begin
                    lvl_next     = lvl_reg - LW'(1);
                    node_ra_addr = AW'(up_node);
                    anc_ra_addr  = anc_addr(up_node, lvl_reg - LW'(1));
                end
            end
            S_Q_DOWN: begin
                if (down_step) begin
                    u_next = anc_ra_data.node;
                    v_next = anc_rb_data.node;
                end
                if (lvl_reg == '0) begin
                    anc_ra_addr = anc_addr(u_next, '0);
                    anc_rb_addr = anc_addr(v_next, '0);
                    state_next  = S_Q_FIN;
                end else begin
                    lvl_next    = lvl_reg - LW'(1);
                    anc_ra_addr = anc_addr(u_next, lvl_reg - LW'(1));
                    anc_rb_addr = anc_addr(v_next, lvl_reg - LW'(1));
                end
            end
            S_Q_FIN: begin
                // Both parents must agree, else the trees are separate
                if (!anc_ra_data.valid || (anc_ra_data != anc_rb_data)) begin
                    res_st_next = ST_ERR;
                    state_next  = S_DONE;
                end else begin
                    u_next       = anc_ra_data.node;
                    node_ra_addr = AW'(anc_ra_data.node);
                    state_next   = S_Q_COST;
                end
            end
            S_Q_COST: begin
                res_st_next   = ST_OK;
                res_anc_next  = u_reg;
                res_cost_next = (cab_reg >= two_cl) ? (cab_reg - two_cl) : '0;
                state_next    = S_DONE;
            end
            S_DONE: begin
                // Hand the result to the output register once it is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_cost_next  = res_cost_reg;
                    m_anc_next   = res_anc_reg;
                    m_st_next    = res_st_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        lvl_reg      <= lvl_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        root_reg     <= root_next;
        edge_reg     <= edge_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        dv_reg       <= dv_next;
        cab_reg      <= cab_next;
        prev_reg     <= prev_next;
        res_cost_reg <= res_cost_next;
        res_anc_reg  <= res_anc_next;
        res_st_reg   <= res_st_next;
        m_cost_reg   <= m_cost_next;
        m_anc_reg    <= m_anc_next;
        m_st_reg     <= m_st_next;
    end

`ifndef SYNTHESIS
    // Ancestor writes only ever touch the row of the node being loaded
    a_anc_row: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.anc_we |-> (anc_wr_addr[AW+LW-1:LW] == AW'(a_reg)))
        else $error("ancestor write outside the loaded row");

    // Queries leave both memories untouched
    a_query_ro: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_Q_CHK || state_reg == S_Q_UP || state_reg == S_Q_DOWN ||
         state_reg == S_Q_FIN || state_reg == S_Q_COST) |-> (wr == '0))
        else $error("memory write during a query");

    // Level counter stays within the table while walking
    a_lvl_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LD_FILL || state_reg == S_Q_UP || state_reg == S_Q_DOWN)
        |-> (lvl_reg <= LVL_TOP))
        else $error("level counter beyond the top level");

    // A finished item shows up on the output the next cycle when the output register is free
    a_done_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && out_free) |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("finished result not presented");

    // An error beat carries zero cost and ancestor
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_st_reg == ST_ERR) |-> (m_cost_reg == '0 && m_anc_reg == '0))
        else $error("error beat with non-zero fields");
`endif

endmodule

`default_nettype wire

FILE: design/tree_path_cost_lca.sv
// Load beat: a check, then the ancestor row is filled one row level per cycle.
// Query beat: a check, then one ancestor-memory read per level going up; when one endpoint lies
//   above the other the cost follows, else one read per level descending jointly, then a parent
//   check and the cost. A beat that fails the loaded check answers straight after the check.
// One beat in flight; s_ready returns with the result (later if m_ready holds it back).
//   After reset s_ready stays low while the node memory is swept.
`default_nettype none

module tree_path_cost_lca
    import tpcl_pkg::*;
#(
    parameter int MAX_NODES  = DEF_MAX_NODES,
    parameter int LOG_LEVELS = DEF_LOG_LEVELS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_action,
    input  wire logic [NODE_W-1:0] s_node_a,
    input  wire logic [NODE_W-1:0] s_node_b,
    input  wire logic              s_is_root,
    input  wire logic [EDGE_W-1:0] s_edge_cost,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [PATH_W-1:0]      m_path_cost,
    output logic [NODE_W-1:0]      m_lca_node,
    output logic                   m_status
);

    localparam int AW        = $clog2(MAX_NODES);
    localparam int LW        = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
    // Rows are padded to a power of two so a level is a plain address field
    localparam int ANC_DEPTH = MAX_NODES << LW;

    logic [AW-1:0]    node_ra_addr, node_rb_addr, node_wr_addr;
    node_ent_t        node_ra_data, node_rb_data, node_wr_data;
    logic [AW+LW-1:0] anc_ra_addr, anc_rb_addr, anc_wr_addr;
    anc_ent_t         anc_ra_data, anc_rb_data, anc_wr_data;
    mem_wr_t          wr;

    node_ent_t node_mem [MAX_NODES];
    anc_ent_t  anc_mem  [ANC_DEPTH];

    // Node memory: one write, two registered reads
    always_ff @(posedge aclk) begin
        if (wr.node_we) begin
            node_mem[node_wr_addr] <= node_wr_data;
        end
        node_ra_data <= node_mem[node_ra_addr];
        node_rb_data <= node_mem[node_rb_addr];
    end

    // Ancestor memory: one write, two registered reads
    always_ff @(posedge aclk) begin
        if (wr.anc_we) begin
            anc_mem[anc_wr_addr] <= anc_wr_data;
        end
        anc_ra_data <= anc_mem[anc_ra_addr];
        anc_rb_data <= anc_mem[anc_rb_addr];
    end

    tpcl_seq #(
        .MAX_NODES  (MAX_NODES),
        .LOG_LEVELS (LOG_LEVELS),
        .AW         (AW),
        .LW         (LW)
    ) u_seq (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_node_a          (s_node_a),
        .s_node_b          (s_node_b),
        .s_is_root         (s_is_root),
        .s_edge_cost       (s_edge_cost),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_path_cost       (m_path_cost),
        .m_lca_node        (m_lca_node),
        .m_status          (m_status),
        .node_ra_addr      (node_ra_addr),
        .node_rb_addr      (node_rb_addr),
        .node_ra_data      (node_ra_data),
        .node_rb_data      (node_rb_data),
        .node_wr_addr      (node_wr_addr),
        .node_wr_data      (node_wr_data),
        .anc_ra_addr       (anc_ra_addr),
        .anc_rb_addr       (anc_rb_addr),
        .anc_ra_data       (anc_ra_data),
        .anc_rb_data       (anc_rb_data),
        .anc_wr_addr       (anc_wr_addr),
        .anc_wr_data       (anc_wr_data),
        .wr                (wr)
    );

endmodule

`default_nettype wire
